// ===== sv/cordic_vector_rotate_core_macros.svh =====
// assertion helpers for the rtl top level
`ifndef CORDIC_VECTOR_ROTATE_CORE_MACROS_SVH
`define CORDIC_VECTOR_ROTATE_CORE_MACROS_SVH

// checked outside reset
`define CVR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define CVR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/cvr_pkg.sv =====
`default_nettype none

package cvr_pkg;

   localparam int WORD_W         = 16;
   localparam int TABLE_LEN      = 11;
   localparam int STEP_COUNT_DEF = 11;
   localparam int GAIN_W         = 9;
   localparam int GAIN_SHIFT     = 8;
   localparam int PROD_W         = WORD_W + GAIN_W;

   localparam logic signed [GAIN_W-1:0] GAIN_FIX = GAIN_W'(155);

   // degrees * 256, truncated toward zero
   localparam logic [WORD_W-1:0] ANGLE_TABLE [0:TABLE_LEN-1] = '{
      16'd11520, 16'd6800, 16'd3593, 16'd1824, 16'd915, 16'd458,
      16'd229,   16'd114,  16'd57,   16'd28,   16'd14
   };

   typedef struct packed {
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] target;
      logic [WORD_W-1:0] acc;
   } stage_type;

endpackage

`default_nettype wire

// ===== sv/cvr_req_if.sv =====
`default_nettype none

interface cvr_req_if;
   logic                           valid;
   logic                           ready;
   logic [cvr_pkg::WORD_W-1:0] vec_x;
   logic [cvr_pkg::WORD_W-1:0] vec_y;
   logic [cvr_pkg::WORD_W-1:0] turn_degrees;

   modport source (output valid, output vec_x, output vec_y, output turn_degrees,
                   input ready);
   modport sink   (input valid, input vec_x, input vec_y, input turn_degrees,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/cvr_rsp_if.sv =====
`default_nettype none

interface cvr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [cvr_pkg::WORD_W-1:0] rot_x;
   logic [cvr_pkg::WORD_W-1:0] rot_y;

   modport source (output valid, output rot_x, output rot_y, input ready);
   modport sink   (input valid, input rot_x, input rot_y, output ready);
endinterface

`default_nettype wire

// ===== sv/cvr_cell.sv =====
`default_nettype none

module cvr_cell #(
   parameter int STAGE = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   output logic                    up_ready,
   input  wire cvr_pkg::stage_type up_data,
   output logic                    dn_valid,
   input  wire logic               dn_ready,
   output cvr_pkg::stage_type      dn_data
);

   logic                           valid_ff;
   logic                           valid_in;
   cvr_pkg::stage_type             data_ff;
   cvr_pkg::stage_type             data_in;
   logic [cvr_pkg::WORD_W-1:0]     diff;
   logic                           turn_pos;
   logic signed [cvr_pkg::WORD_W-1:0] xs;
   logic signed [cvr_pkg::WORD_W-1:0] ys;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      diff     = up_data.target - up_data.acc;
      // exact zero turns the negative way
      turn_pos = !diff[cvr_pkg::WORD_W-1] && (diff != '0);
      xs       = $signed(up_data.x) >>> STAGE;
      ys       = $signed(up_data.y) >>> STAGE;
      data_in.target = up_data.target;
      if (turn_pos) begin
         data_in.x   = up_data.x - ys;
         data_in.y   = up_data.y + xs;
         data_in.acc = up_data.acc + cvr_pkg::ANGLE_TABLE[STAGE];
      end else begin
         data_in.x   = up_data.x + ys;
         data_in.y   = up_data.y - xs;
         data_in.acc = up_data.acc - cvr_pkg::ANGLE_TABLE[STAGE];
      end
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/cvr_gain.sv =====
`default_nettype none

module cvr_gain (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   output logic                    up_ready,
   input  wire cvr_pkg::stage_type up_data,
   cvr_rsp_if.source               rsp_ch
);

   logic                                valid_ff;
   logic                                valid_in;
   logic [cvr_pkg::WORD_W-1:0]          rot_x_ff;
   logic [cvr_pkg::WORD_W-1:0]          rot_y_ff;
   logic signed [cvr_pkg::PROD_W-1:0]   prod_x;
   logic signed [cvr_pkg::PROD_W-1:0]   prod_y;

   assign up_ready     = !valid_ff || rsp_ch.ready;
   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.rot_x = rot_x_ff;
   assign rsp_ch.rot_y = rot_y_ff;

   always_comb begin
      prod_x   = cvr_pkg::PROD_W'($signed(up_data.x))
               * cvr_pkg::PROD_W'(cvr_pkg::GAIN_FIX);
      prod_y   = cvr_pkg::PROD_W'($signed(up_data.y))
               * cvr_pkg::PROD_W'(cvr_pkg::GAIN_FIX);
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // shift right by 8 and wrap to the word
   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         rot_x_ff <= prod_x[cvr_pkg::GAIN_SHIFT +: cvr_pkg::WORD_W];
         rot_y_ff <= prod_y[cvr_pkg::GAIN_SHIFT +: cvr_pkg::WORD_W];
      end
   end

endmodule

`default_nettype wire

// ===== sv/cordic_vector_rotate_core.sv =====
// CORDIC rotation of a signed Q8.8 vector by a signed Q8.8 angle in degrees.
// One item is taken per clock while the output is not stalled; each
// micro-rotation is one cell of a pipelined chain, followed by a gain
// register that scales by 155/256, so each result passes every cell in turn.
// Every cell has its own valid bit and ready, so bubbles close up and a new
// item enters while a finished result still waits at the output.
`default_nettype none

`include "cordic_vector_rotate_core_macros.svh"

module cordic_vector_rotate_core #(
   parameter int STEP_COUNT = cvr_pkg::STEP_COUNT_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   cvr_req_if.sink   req_ch,
   cvr_rsp_if.source rsp_ch
);

   logic               stage_valid [0:STEP_COUNT];
   logic               stage_ready [0:STEP_COUNT];
   cvr_pkg::stage_type stage_data  [0:STEP_COUNT];

   assign stage_valid[0]        = req_ch.valid;
   assign req_ch.ready          = stage_ready[0];
   assign stage_data[0].x       = req_ch.vec_x;
   assign stage_data[0].y       = req_ch.vec_y;
   assign stage_data[0].target  = req_ch.turn_degrees;
   assign stage_data[0].acc     = '0;

   for (genvar i = 0; i < STEP_COUNT; i++) begin : g_cell
      cvr_cell #(
         .STAGE (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stage_valid[i]),
         .up_ready (stage_ready[i]),
         .up_data  (stage_data[i]),
         .dn_valid (stage_valid[i+1]),
         .dn_ready (stage_ready[i+1]),
         .dn_data  (stage_data[i+1])
      );
   end

   cvr_gain u_gain (
      .clock    (clock),
      .reset    (reset),
      .up_valid (stage_valid[STEP_COUNT]),
      .up_ready (stage_ready[STEP_COUNT]),
      .up_data  (stage_data[STEP_COUNT]),
      .rsp_ch   (rsp_ch)
   );

   `CVR_ASSERT_ALWAYS(a_rsp_idle_after_reset, reset |=> !rsp_ch.valid, "result valid after reset")
   `CVR_ASSERT(a_no_invented_rsp, !stage_valid[STEP_COUNT] && !rsp_ch.valid |=> !rsp_ch.valid, "result without item")
   `CVR_ASSERT(a_first_cell_free, !stage_valid[1] |-> req_ch.ready, "empty first cell refused item")

endmodule

`default_nettype wire

// ===== tb/tb_cordic_vector_rotate_core.sv =====
module tb_cordic_vector_rotate_core;
   timeunit 1ns;
   timeprecision 1ps;

   import cvr_pkg::*;

   localparam int STEPS        = STEP_COUNT_DEF;
   localparam int RANDOM_ITEMS = 1500;
   localparam int FLUSH_CYCLES = STEPS + 10;

   typedef struct packed {
      logic [WORD_W-1:0] rot_x;
      logic [WORD_W-1:0] rot_y;
   } rotation_t;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BEAT} stall_mode_e;

   class rotation_scoreboard;
      rotation_t expected_rot[$];
      int        mismatches;
      int        checked;

      function new();
         mismatches = 0;
         checked    = 0;
      endfunction

      function rotation_t rotate_vector(logic signed [WORD_W-1:0] x_in,
                                        logic signed [WORD_W-1:0] y_in,
                                        logic signed [WORD_W-1:0] angle);
         logic signed [WORD_W-1:0] x, y, acc, diff, x_sh, y_sh;
         int                       gain_x, gain_y;
         rotation_t                r;
         x   = x_in;
         y   = y_in;
         acc = '0;
         for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
            x_sh = x >>> i;
            y_sh = y >>> i;
            diff = angle - acc;
            // zero difference turns the negative way
            if (diff > 0) begin
               x   = x - y_sh;
               y   = y + x_sh;
               acc = acc + ANGLE_TABLE[i];
            end else begin
               x   = x + y_sh;
               y   = y - x_sh;
               acc = acc - ANGLE_TABLE[i];
            end
         end
         gain_x  = int'(x) * int'(GAIN_FIX);
         gain_y  = int'(y) * int'(GAIN_FIX);
         r.rot_x = WORD_W'(gain_x >>> GAIN_SHIFT);
         r.rot_y = WORD_W'(gain_y >>> GAIN_SHIFT);
         return r;
      endfunction

      function void note_vector(logic [WORD_W-1:0] x, logic [WORD_W-1:0] y,
                                logic [WORD_W-1:0] angle);
         expected_rot.push_back(rotate_vector(x, y, angle));
      endfunction

      function void check_rotation(logic [WORD_W-1:0] rx, logic [WORD_W-1:0] ry);
         rotation_t exp_rot;
         if (expected_rot.size() == 0) begin
            $error("unexpected item: rot_x %0d rot_y %0d", $signed(rx), $signed(ry));
            mismatches++;
            return;
         end
         exp_rot = expected_rot.pop_front();
         checked++;
         if (exp_rot.rot_x !== rx) begin
            $error("rot_x mismatch: expected %0d, actual %0d",
                   $signed(exp_rot.rot_x), $signed(rx));
            mismatches++;
         end
         if (exp_rot.rot_y !== ry) begin
            $error("rot_y mismatch: expected %0d, actual %0d",
                   $signed(exp_rot.rot_y), $signed(ry));
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_rot.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   cvr_req_if req_ch();
   cvr_rsp_if rsp_ch();

   rotation_scoreboard sb = new();

   int directed_count;
   int random_count;

   cordic_vector_rotate_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         sb.note_vector(req_ch.vec_x, req_ch.vec_y, req_ch.turn_degrees);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_rotation(rsp_ch.rot_x, rsp_ch.rot_y);
      end
   end

   // receiver stall pattern, cycling through open, light, heavy and beat styles
   initial begin
      int          stall_cycle;
      stall_mode_e mode;
      stall_cycle  = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         mode = stall_mode_e'((stall_cycle / 256) % 4);
         case (mode)
            RX_OPEN:  rsp_ch.ready <= 1'b1;
            RX_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default:  rsp_ch.ready <= ((stall_cycle % 9) < 4);
         endcase
         stall_cycle++;
      end
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_vector(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
                              input logic [WORD_W-1:0] angle);
      req_ch.valid        <= 1'b1;
      req_ch.vec_x        <= x;
      req_ch.vec_y        <= y;
      req_ch.turn_degrees <= angle;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_rotations();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_corner();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'hffff;
         4:       return 16'h0001;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   task automatic make_random(output logic [WORD_W-1:0] x, output logic [WORD_W-1:0] y,
                              output logic [WORD_W-1:0] angle);
      int kind;
      int acc;
      int depth;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         x     = WORD_W'($urandom);
         y     = WORD_W'($urandom);
         angle = WORD_W'($urandom);
      end else if (kind < 70) begin
         // moderate vectors and angles within about +/- 99 degrees
         x     = WORD_W'($urandom_range(0, 16383) - 8192);
         y     = WORD_W'($urandom_range(0, 16383) - 8192);
         angle = WORD_W'($urandom_range(0, 50688) - 25344);
      end else if (kind < 85) begin
         // angle on a partial sum of the table to hit zero differences
         acc   = 0;
         depth = $urandom_range(1, TABLE_LEN - 1);
         for (int i = 0; i < depth; i++) begin
            if ($urandom_range(0, 1) != 0) acc += int'(ANGLE_TABLE[i]);
            else acc -= int'(ANGLE_TABLE[i]);
         end
         x     = WORD_W'($urandom_range(0, 8191) - 4096);
         y     = WORD_W'($urandom_range(0, 8191) - 4096);
         angle = WORD_W'(acc);
      end else begin
         x     = pick_corner();
         y     = pick_corner();
         angle = pick_corner();
      end
   endtask

   initial begin
      logic [WORD_W-1:0] x, y, angle;
      int                burst_left;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.vec_x        = '0;
      req_ch.vec_y        = '0;
      req_ch.turn_degrees = '0;
      directed_count      = 0;
      random_count        = 0;
      burst_left          = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed corners, right angles and exact table sums
      send_vector(16'sd0, 16'sd0, 16'sd0);
      send_vector(16'sd256, 16'sd0, 16'sd23040);
      send_vector(16'sd256, 16'sd0, -16'sd23040);
      send_vector(16'sd256, 16'sd0, 16'sd11520);
      send_vector(16'sd0, 16'sd256, 16'sd18320);
      send_vector(16'sd256, 16'sd256, 16'sd4720);
      send_vector(16'sd512, -16'sd256, 16'sd14727);
      send_vector(16'sd256, 16'sd0, 16'sd7680);
      send_vector(-16'sd256, 16'sd128, -16'sd11520);
      send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_vector(16'sh8000, 16'sh8000, 16'sh8000);
      send_vector(16'sh8000, 16'sh7fff, 16'sd1);
      send_vector(16'sh7fff, 16'sh8000, -16'sd1);
      send_vector(-16'sd1, -16'sd1, 16'sd0);
      send_vector(16'sd1, 16'sd1, -16'sd1);
      send_vector(16'sh7fff, 16'sh7fff, 16'sh8000);
      send_vector(16'sh7fff, 16'sd0, 16'sd0);
      send_vector(16'sd12345, -16'sd4321, 16'sh7fff);
      send_vector(16'sd0, 16'sh8000, -16'sd23040);
      directed_count = 19;
      drain_rotations();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            drain_rotations();
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
         end
         make_random(x, y, angle);
         send_vector(x, y, angle);
         burst_left--;
         random_count++;
      end

      drain_rotations();
      repeat (FLUSH_CYCLES) @(posedge clock);

      $display("rotated %0d directed and %0d random vectors under bursty input",
               directed_count, random_count);
      $display("and mixed output stalls: %0d results checked, %0d mismatches",
               sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
